### sv/oesm_pkg.sv
// Shared widths, codes and constants of the operating envelope state machine.
package oesm_pkg;

    localparam int SCORE_W   = 18;
    localparam int TIME_W    = 20;
    localparam int LEVEL_W   = 17;
    localparam int ZONE_W    = 2;
    localparam int HEALTH_W  = 2;
    localparam int STATE_W   = 3;
    localparam int CFG_IDX_W = 2;

    // Effective score headroom: three Q1.16 scalings of an 18-bit score stay
    // well inside 22 signed bits.
    localparam int EFF_W     = 22;
    localparam int ACC_W     = EFF_W + 1;
    localparam int FRAC_W    = 16;
    localparam int CNT_W     = 5;
    localparam int PASS_W    = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 8;

    // Envelope state codes as they appear on the result channel
    typedef enum logic [STATE_W-1:0] {
        ENV_IN     = 3'd0,
        ENV_EDGE   = 3'd1,
        ENV_PREP   = 3'd2,
        ENV_ACTIVE = 3'd3,
        ENV_OUT    = 3'd4,
        ENV_OVER   = 3'd5
    } env_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGE_ENTER = 2'd0,
        REG_OUT_ENTER  = 2'd1,
        REG_DEGRADE    = 2'd2
    } cfg_index_t;

    localparam logic [ZONE_W-1:0]   ZONE_C          = 2'd2;
    localparam logic [HEALTH_W-1:0] HEALTH_DEGRADED = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_CRITICAL = 2'd2;

    localparam logic [LEVEL_W-1:0] EDGE_ENTER_RST = 17'd45875;
    localparam logic [LEVEL_W-1:0] OUT_ENTER_RST  = 17'd19661;
    localparam logic [LEVEL_W-1:0] DEGRADE_RST    = 17'd52429;
    localparam logic [LEVEL_W-1:0] Q_ONE          = 17'd65536;
    localparam logic [LEVEL_W-1:0] Q_HEARTBEAT    = 17'd45875;
    localparam logic [LEVEL_W-1:0] Q_ZONE_C_OUT   = 17'd39322;

endpackage

### sv/operating_envelope_state_machine.sv
// Top level of the operating envelope state machine with its bit-serial scaler.
//
// Usage: one beat on the s_ channel carries one control tick (score, times,
// event flags, zone, health; score_invalid rides in s_tuser). One beat on the
// m_ channel carries the resulting envelope state and a state-changed flag.
// Thresholds and the degrade factor must be written through the cfg_ port only
// while the block is idle, which the block does not enforce; writes to index 3 are ignored.
//
// Scaling: the effective score is built by three Q1.16 scaling passes
// (degraded health, stale input, lost heartbeat) through one shift-add
// multiplier that consumes one factor bit per cycle. A pass that does not
// apply multiplies by exactly 1.0. A final decision step then sets the result
// beat; the block accepts no new tick until that decision is done.
//
// The result sits in an output register, so the next tick is accepted while
// an earlier result still waits. If the receiver stalls, the finished
// decision holds (and the envelope state is not updated) until the output
// register frees up; s_tready stays low meanwhile.
//
// Reset: the envelope state returns to In, the registers take their default
// levels (0.7, 0.3, 0.8), and both channels come up empty.
module operating_envelope_state_machine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: score[17:0], time_to_limit[37:18], time_to_safe_stop[57:38],
    // override_on[58], reflex_on[59], alert_critical[60],
    // alert_stop_required[61], primary_stale[62], heartbeat_lost[63],
    // zone[65:64], health[67:66], zero pad[71:68]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [oesm_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: score_invalid[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata: envelope_state[2:0], state_changed[3], zero pad[7:4]
    output logic [oesm_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                 cfg_we,
    input  logic [oesm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [oesm_pkg::LEVEL_W-1:0]         cfg_data
);

    // Control sequencer: idle, serial scaling, final decision
    typedef enum logic [2:0] {
        FSM_IDLE   = 3'b001,
        FSM_MUL    = 3'b010,
        FSM_FINISH = 3'b100
    } fsm_t;

    // Fields of the tick that the decision needs after the scaling passes
    typedef struct packed {
        logic                              invalid;
        logic [oesm_pkg::TIME_W-1:0]       tdl;
        logic [oesm_pkg::TIME_W-1:0]       tmr;
        logic                              override_on;
        logic                              reflex_on;
        logic                              critical;
        logic                              stop_req;
        logic                              stale;
        logic                              hb_lost;
        logic [oesm_pkg::ZONE_W-1:0]       zone;
        logic [oesm_pkg::HEALTH_W-1:0]     health;
    } tick_t;

    localparam logic [oesm_pkg::CNT_W-1:0]  CNT_LAST  = oesm_pkg::CNT_W'(oesm_pkg::FRAC_W);
    localparam logic [oesm_pkg::PASS_W-1:0] PASS_LAST = 2'd2;

    fsm_t                                  fsm_reg, fsm_next;
    tick_t                                 tick_reg, tick_next;
    logic signed [oesm_pkg::EFF_W-1:0]     eff_reg, eff_next;
    logic signed [oesm_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [oesm_pkg::LEVEL_W-1:0]          mplr_reg, mplr_next;
    logic [oesm_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [oesm_pkg::PASS_W-1:0]           pass_reg, pass_next;
    oesm_pkg::env_state_t                  cur_reg, cur_next;
    logic                                  m_tvalid_reg, m_tvalid_next;
    logic [oesm_pkg::M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [oesm_pkg::LEVEL_W-1:0]          edge_lvl_reg, edge_lvl_next;
    logic [oesm_pkg::LEVEL_W-1:0]          out_lvl_reg, out_lvl_next;
    logic [oesm_pkg::LEVEL_W-1:0]          degrade_reg, degrade_next;

    logic                                  in_beat;
    logic                                  out_free;
    logic signed [oesm_pkg::ACC_W-1:0]     addend;
    logic signed [oesm_pkg::ACC_W-1:0]     sum;
    logic [oesm_pkg::LEVEL_W-1:0]          factor;
    logic [oesm_pkg::PASS_W-1:0]           pass_up;
    tick_t                                 tick_up;
    logic [oesm_pkg::LEVEL_W-1:0]          out_thr;
    logic signed [oesm_pkg::EFF_W-1:0]     edge_s;
    logic signed [oesm_pkg::EFF_W-1:0]     out_s;
    oesm_pkg::env_state_t                  ord_state;
    oesm_pkg::env_state_t                  decided;
    tick_t                                 s_tick;

    assign s_tready = (fsm_reg == FSM_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign s_tick.invalid     = s_tuser;
    assign s_tick.tdl         = s_tdata[37:18];
    assign s_tick.tmr         = s_tdata[57:38];
    assign s_tick.override_on = s_tdata[58];
    assign s_tick.reflex_on   = s_tdata[59];
    assign s_tick.critical    = s_tdata[60];
    assign s_tick.stop_req    = s_tdata[61];
    assign s_tick.stale       = s_tdata[62];
    assign s_tick.hb_lost     = s_tdata[63];
    assign s_tick.zone        = s_tdata[65:64];
    assign s_tick.health      = s_tdata[67:66];

    // Pass about to start and the tick it scales: the first pass of a new
    // tick from idle, else the pass after the current one
    assign pass_up = (fsm_reg == FSM_IDLE) ? '0 : pass_reg + 1'b1;
    assign tick_up = (fsm_reg == FSM_IDLE) ? s_tick : tick_reg;

    // Factor of the pass about to start; 1.0 leaves the score untouched
    always_comb
    begin
        case (pass_up)
            2'd0:    factor = (tick_up.health == oesm_pkg::HEALTH_DEGRADED) ?
                              degrade_reg : oesm_pkg::Q_ONE;
            2'd1:    factor = tick_up.stale ? degrade_reg : oesm_pkg::Q_ONE;
            2'd2:    factor = tick_up.hb_lost ? oesm_pkg::Q_HEARTBEAT : oesm_pkg::Q_ONE;
            default: factor = oesm_pkg::Q_ONE;
        endcase
    end

    // One shift-add step: add the score if the factor bit is set, then shift
    // the partial product right. After the last bit the sum is the product
    // floored by 2^16.
    assign addend = mplr_reg[0] ? {eff_reg[oesm_pkg::EFF_W-1], eff_reg} : '0;
    assign sum    = acc_reg + addend;

    // Zone C raises the out threshold to at least 0.6
    assign out_thr = ((tick_reg.zone == oesm_pkg::ZONE_C) &&
                      (out_lvl_reg < oesm_pkg::Q_ZONE_C_OUT)) ?
                     oesm_pkg::Q_ZONE_C_OUT : out_lvl_reg;
    assign edge_s  = $signed({{(oesm_pkg::EFF_W-oesm_pkg::LEVEL_W){1'b0}}, edge_lvl_reg});
    assign out_s   = $signed({{(oesm_pkg::EFF_W-oesm_pkg::LEVEL_W){1'b0}}, out_thr});

    // Ordinary transitions on the effective score
    always_comb
    begin
        case (cur_reg)
            oesm_pkg::ENV_IN:
            begin
                if (eff_reg <= 0 || eff_reg < out_s)
                    ord_state = oesm_pkg::ENV_OUT;
                else if (eff_reg < edge_s)
                    ord_state = oesm_pkg::ENV_EDGE;
                else
                    ord_state = oesm_pkg::ENV_IN;
            end
            oesm_pkg::ENV_EDGE:
            begin
                if (eff_reg >= edge_s)
                    ord_state = oesm_pkg::ENV_IN;
                else if (eff_reg < out_s)
                    ord_state = oesm_pkg::ENV_OUT;
                else if (tick_reg.tdl <= tick_reg.tmr)
                    ord_state = oesm_pkg::ENV_PREP;
                else
                    ord_state = oesm_pkg::ENV_EDGE;
            end
            oesm_pkg::ENV_PREP:
                ord_state = tick_reg.stop_req ? oesm_pkg::ENV_ACTIVE : oesm_pkg::ENV_PREP;
            oesm_pkg::ENV_ACTIVE:
                ord_state = (!tick_reg.critical && eff_reg >= edge_s) ?
                            oesm_pkg::ENV_IN : oesm_pkg::ENV_ACTIVE;
            default:
            begin
                if (eff_reg >= edge_s)
                    ord_state = oesm_pkg::ENV_IN;
                else if (eff_reg >= out_s)
                    ord_state = oesm_pkg::ENV_EDGE;
                else
                    ord_state = oesm_pkg::ENV_OUT;
            end
        endcase
    end

    // Priority checks ahead of the ordinary transitions
    always_comb
    begin
        if (tick_reg.override_on || tick_reg.reflex_on)
            decided = oesm_pkg::ENV_OVER;
        else if (tick_reg.invalid)
            decided = oesm_pkg::ENV_OUT;
        else if (tick_reg.critical || tick_reg.stop_req ||
                 tick_reg.health == oesm_pkg::HEALTH_CRITICAL)
            decided = oesm_pkg::ENV_PREP;
        else
            decided = ord_state;
    end

    always_comb
    begin
        fsm_next      = fsm_reg;
        tick_next     = tick_reg;
        eff_next      = eff_reg;
        acc_next      = acc_reg;
        mplr_next     = mplr_reg;
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        edge_lvl_next = edge_lvl_reg;
        out_lvl_next  = out_lvl_reg;
        degrade_next  = degrade_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                oesm_pkg::REG_EDGE_ENTER: edge_lvl_next = cfg_data;
                oesm_pkg::REG_OUT_ENTER:  out_lvl_next  = cfg_data;
                oesm_pkg::REG_DEGRADE:    degrade_next  = cfg_data;
                default:                  ;
            endcase
        end

        case (fsm_reg)
            FSM_IDLE:
            begin
                if (in_beat)
                begin
                    tick_next = s_tick;
                    eff_next  = oesm_pkg::EFF_W'($signed(s_tdata[oesm_pkg::SCORE_W-1:0]));
                    acc_next  = '0;
                    cnt_next  = '0;
                    pass_next = '0;
                    mplr_next = factor;
                    fsm_next  = FSM_MUL;
                end
            end
            FSM_MUL:
            begin
                acc_next  = sum >>> 1;
                mplr_next = mplr_reg >> 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    eff_next = sum[oesm_pkg::EFF_W-1:0];
                    acc_next = '0;
                    cnt_next = '0;
                    if (pass_reg == PASS_LAST)
                        fsm_next = FSM_FINISH;
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                        mplr_next = factor;
                    end
                end
            end
            FSM_FINISH:
            begin
                // Hold the decision until the output register frees up
                if (out_free)
                begin
                    cur_next      = decided;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, (decided != cur_reg), decided};
                    fsm_next      = FSM_IDLE;
                end
            end
            default:
                fsm_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= FSM_IDLE;
            cur_reg      <= oesm_pkg::ENV_IN;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            pass_reg     <= '0;
            edge_lvl_reg <= oesm_pkg::EDGE_ENTER_RST;
            out_lvl_reg  <= oesm_pkg::OUT_ENTER_RST;
            degrade_reg  <= oesm_pkg::DEGRADE_RST;
        end
        else
        begin
            fsm_reg      <= fsm_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            pass_reg     <= pass_next;
            edge_lvl_reg <= edge_lvl_next;
            out_lvl_reg  <= out_lvl_next;
            degrade_reg  <= degrade_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg    <= tick_next;
        eff_reg     <= eff_next;
        acc_reg     <= acc_next;
        mplr_reg    <= mplr_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

### sv/oesm_checker.sv
// Port-level checks of the operating envelope state machine and their binding.
module oesm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [oesm_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The MrcActive state is never reached
    a_no_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] != oesm_pkg::ENV_ACTIVE)
        else $error("MrcActive state reported");

    // One tick at a time: after an accepted beat the input side closes
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in work");

    // No result appears the cycle after a tick is accepted (scaling is serial)
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind operating_envelope_state_machine oesm_checker u_oesm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
